@@ hdl/lps_pkg.sv @@
// Shared types, character codes and helper functions for the two-integer line parser.
package lps_pkg;

  localparam int MAX_LINE_DEF = 64;
  localparam int VAL_W        = 32;

  localparam logic [VAL_W-1:0] MAG_LIMIT   = 32'h8000_0000;
  localparam logic [VAL_W-1:0] MAG_CLAMP   = 32'h8000_0001;
  localparam logic [VAL_W-1:0] MAG_MAX_POS = 32'h7FFF_FFFF;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PARSE,
    ST_EMIT
  } state_t;

  // Per-part token phase during the parse pass.
  typedef enum logic [1:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DIG,
    PH_TRAIL
  } phase_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Clamp a sign/magnitude pair into the signed 32-bit range.
  function automatic logic [VAL_W-1:0] sat_value(input logic [VAL_W-1:0] mag,
                                                 input logic             neg);
    logic [VAL_W-1:0] r;
    if (neg) begin
      r = (mag >= MAG_LIMIT) ? MAG_LIMIT : (32'd0 - mag);
    end else begin
      r = (mag > MAG_MAX_POS) ? MAG_MAX_POS : mag;
    end
    return r;
  endfunction

endpackage

@@ hdl/two_integer_line_parser.sv @@
// Top level of the two-integer line parser: byte intake, line sequencer and result register.
//
// Bytes arrive one per transfer on the in_ stream. While enabled, CR is dropped, LF ends the
// line and every other byte is appended to the line buffer. Appending past MAX_LINE bytes
// empties the buffer and yields an overflow result. An LF on a non-empty line starts a walk of
// the buffer through its single read port: a scan pass finds the last non-whitespace character
// and the split point (first inner space, else first comma), then, if a split was found, a parse
// pass runs every character through one shared times-ten accumulate unit. The walk keeps
// in_tready low until the result is loaded, including any wait for the result register to free up.
// Results sit in an output register, so the next byte is taken while a result still waits
// on out_tready. No clearing pass is needed after reset. Disabled bytes are taken and ignored.
module two_integer_line_parser #(
  parameter int MAX_LINE = lps_pkg::MAX_LINE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,     // enable
  // received bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] rx_byte
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,    // [31:0] shoulder_target, [63:32] elbow_target
  output logic [1:0]  out_tuser     // [1:0] status
);

  localparam int AW = $clog2(MAX_LINE);
  localparam int LW = $clog2(MAX_LINE + 1);
  localparam logic [LW-1:0] LEN_FULL = LW'(MAX_LINE);

  // ---------------------------------------------------------------- registers
  lps_pkg::state_t  state_r, state_nxt;
  logic             enable_r;
  logic [LW-1:0]    len_r, len_nxt;
  logic [LW-1:0]    issue_r, issue_nxt;     // next buffer address to read
  logic             dv_r, dv_nxt;           // read data valid this cycle
  logic [AW-1:0]    didx_r, didx_nxt;       // index of the data now on rd_data
  logic             out_valid_r, out_valid_nxt;
  lps_pkg::status_t status_r, status_nxt;
  logic [31:0]      shoulder_r, shoulder_nxt;
  logic [31:0]      elbow_r, elbow_nxt;

  // scan pass
  logic             seen_r, seen_nxt;       // a non-whitespace char seen
  logic             sp_found_r, sp_found_nxt;
  logic [AW-1:0]    sp_pos_r, sp_pos_nxt;
  logic             cm_found_r, cm_found_nxt;
  logic [AW-1:0]    cm_pos_r, cm_pos_nxt;
  logic [AW-1:0]    last_nw_r, last_nw_nxt;

  // parse pass
  logic [AW-1:0]    split_r, split_nxt;
  lps_pkg::phase_t  phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [31:0]      mag_r, mag_nxt;
  logic             bad_r, bad_nxt;
  logic [31:0]      first_r, first_nxt;
  logic [31:0]      second_r, second_nxt;
  lps_pkg::status_t pend_r, pend_nxt;

  // ---------------------------------------------------------------- decode
  logic        in_fire, take, is_lf, lf_line, ovf, store;
  logic        pass_done, out_free, scan_ok, use_space;
  logic [7:0]  rd_data;
  logic [31:0] acc_mag;
  logic        part_ok;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == lps_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign take      = in_fire && enable_r && (in_tdata != lps_pkg::CHAR_CR);
  assign is_lf     = (in_tdata == lps_pkg::CHAR_LF);
  assign lf_line   = take && is_lf && (len_r != '0);
  assign ovf       = take && !is_lf && (len_r == LEN_FULL);
  assign store     = take && !is_lf && (len_r != LEN_FULL);

  assign pass_done = (issue_r == len_r) && !dv_r;
  assign out_free  = !out_valid_r || out_tready;
  // a space splits only if some non-whitespace follows it
  assign use_space = sp_found_r && (sp_pos_r < last_nw_r);
  assign scan_ok   = seen_r && (use_space || cm_found_r);
  assign part_ok   = (phase_r == lps_pkg::PH_DIG) || (phase_r == lps_pkg::PH_TRAIL);

  lps_line_mem #(
    .DEPTH (MAX_LINE),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (len_r[AW-1:0]),
    .wr_data (in_tdata),
    .rd_addr (issue_r[AW-1:0]),
    .rd_data (rd_data)
  );

  lps_dec_acc u_acc (
    .mag_i   (mag_r),
    .digit_i (rd_data[3:0]),
    .mag_o   (acc_mag)
  );

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lps_pkg::ST_IDLE: begin
        if (lf_line) begin
          state_nxt = lps_pkg::ST_SCAN;
        end else if (ovf) begin
          state_nxt = lps_pkg::ST_EMIT;
        end
      end
      lps_pkg::ST_SCAN: begin
        if (pass_done) begin
          state_nxt = scan_ok ? lps_pkg::ST_PARSE : lps_pkg::ST_EMIT;
        end
      end
      lps_pkg::ST_PARSE: begin
        if (pass_done) begin
          state_nxt = lps_pkg::ST_EMIT;
        end
      end
      lps_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = lps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lps_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    len_nxt       = len_r;
    issue_nxt     = issue_r;
    dv_nxt        = 1'b0;
    didx_nxt      = didx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    status_nxt    = status_r;
    shoulder_nxt  = shoulder_r;
    elbow_nxt     = elbow_r;
    seen_nxt      = seen_r;
    sp_found_nxt  = sp_found_r;
    sp_pos_nxt    = sp_pos_r;
    cm_found_nxt  = cm_found_r;
    cm_pos_nxt    = cm_pos_r;
    last_nw_nxt   = last_nw_r;
    split_nxt     = split_r;
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    bad_nxt       = bad_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    pend_nxt      = pend_r;

    // read issue, shared by both passes
    if ((state_r == lps_pkg::ST_SCAN || state_r == lps_pkg::ST_PARSE) &&
        (issue_r != len_r)) begin
      issue_nxt = issue_r + LW'(1);
      dv_nxt    = 1'b1;
      didx_nxt  = issue_r[AW-1:0];
    end

    case (state_r)
      lps_pkg::ST_IDLE: begin
        issue_nxt    = '0;
        seen_nxt     = 1'b0;
        sp_found_nxt = 1'b0;
        cm_found_nxt = 1'b0;
        if (store) begin
          len_nxt = len_r + LW'(1);
        end else if (ovf) begin
          len_nxt  = '0;
          pend_nxt = lps_pkg::STATUS_OVERFLOW;
        end
      end

      lps_pkg::ST_SCAN: begin
        if (dv_r) begin
          if (!lps_pkg::is_ws(rd_data)) begin
            seen_nxt    = 1'b1;
            last_nw_nxt = didx_r;
          end
          if (rd_data == lps_pkg::CHAR_SPACE && seen_r && !sp_found_r) begin
            sp_found_nxt = 1'b1;
            sp_pos_nxt   = didx_r;
          end
          if (rd_data == lps_pkg::CHAR_COMMA && !cm_found_r) begin
            cm_found_nxt = 1'b1;
            cm_pos_nxt   = didx_r;
          end
        end
        if (pass_done) begin
          issue_nxt = '0;
          split_nxt = use_space ? sp_pos_r : cm_pos_r;
          phase_nxt = lps_pkg::PH_LEAD;
          neg_nxt   = 1'b0;
          mag_nxt   = '0;
          bad_nxt   = 1'b0;
          if (!scan_ok) begin
            len_nxt  = '0;
            pend_nxt = lps_pkg::STATUS_INVALID;
          end
        end
      end

      lps_pkg::ST_PARSE: begin
        if (dv_r) begin
          if (didx_r == split_r) begin
            // close the first part, open the second
            if (!part_ok) begin
              bad_nxt = 1'b1;
            end
            first_nxt = lps_pkg::sat_value(mag_r, neg_r);
            phase_nxt = lps_pkg::PH_LEAD;
            neg_nxt   = 1'b0;
            mag_nxt   = '0;
          end else begin
            case (phase_r)
              lps_pkg::PH_LEAD: begin
                if (lps_pkg::is_digit(rd_data)) begin
                  phase_nxt = lps_pkg::PH_DIG;
                  mag_nxt   = acc_mag;
                end else if (rd_data == lps_pkg::CHAR_PLUS ||
                             rd_data == lps_pkg::CHAR_MINUS) begin
                  phase_nxt = lps_pkg::PH_SIGN;
                  neg_nxt   = (rd_data == lps_pkg::CHAR_MINUS);
                end else if (!lps_pkg::is_ws(rd_data)) begin
                  bad_nxt = 1'b1;
                end
              end
              lps_pkg::PH_SIGN: begin
                if (lps_pkg::is_digit(rd_data)) begin
                  phase_nxt = lps_pkg::PH_DIG;
                  mag_nxt   = acc_mag;
                end else begin
                  bad_nxt = 1'b1;
                end
              end
              lps_pkg::PH_DIG: begin
                if (lps_pkg::is_digit(rd_data)) begin
                  mag_nxt = acc_mag;
                end else if (lps_pkg::is_ws(rd_data)) begin
                  phase_nxt = lps_pkg::PH_TRAIL;
                end else begin
                  bad_nxt = 1'b1;
                end
              end
              lps_pkg::PH_TRAIL: begin
                if (!lps_pkg::is_ws(rd_data)) begin
                  bad_nxt = 1'b1;
                end
              end
              default: bad_nxt = 1'b1;
            endcase
          end
        end
        if (pass_done) begin
          len_nxt    = '0;
          second_nxt = lps_pkg::sat_value(mag_r, neg_r);
          pend_nxt   = (bad_r || !part_ok) ? lps_pkg::STATUS_INVALID : lps_pkg::STATUS_OK;
        end
      end

      lps_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          status_nxt    = pend_r;
          shoulder_nxt  = (pend_r == lps_pkg::STATUS_OK) ? first_r : '0;
          elbow_nxt     = (pend_r == lps_pkg::STATUS_OK) ? second_r : '0;
        end
      end

      default: begin
        len_nxt = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lps_pkg::ST_IDLE;
      enable_r    <= 1'b0;
      len_r       <= '0;
      issue_r     <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      issue_r     <= issue_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        enable_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    didx_r     <= didx_nxt;
    status_r   <= status_nxt;
    shoulder_r <= shoulder_nxt;
    elbow_r    <= elbow_nxt;
    seen_r     <= seen_nxt;
    sp_found_r <= sp_found_nxt;
    sp_pos_r   <= sp_pos_nxt;
    cm_found_r <= cm_found_nxt;
    cm_pos_r   <= cm_pos_nxt;
    last_nw_r  <= last_nw_nxt;
    split_r    <= split_nxt;
    phase_r    <= phase_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    bad_r      <= bad_nxt;
    first_r    <= first_nxt;
    second_r   <= second_nxt;
    pend_r     <= pend_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {elbow_r, shoulder_r};

  // ---------------------------------------------------------------- assertions
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_FULL)
    else $error("line length beyond buffer depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != lps_pkg::STATUS_OK) |-> (shoulder_r == '0) && (elbow_r == '0))
    else $error("failed result carries nonzero values");

  a_lf_busy: assert property (@(posedge clk) disable iff (!rst_n)
    lf_line |=> !in_tready)
    else $error("line end did not start the walk");

  a_ovf_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ovf |=> (len_r == '0) && (state_r == lps_pkg::ST_EMIT))
    else $error("overflow did not empty the buffer");

endmodule

@@ hdl/lps_line_mem.sv @@
// Line buffer: one write port, one registered read port.
module lps_line_mem #(
  parameter int DEPTH = lps_pkg::MAX_LINE_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/lps_dec_acc.sv @@
// Shared decimal accumulate unit: mag*10 + digit, clamped just above 2^31.
module lps_dec_acc (
  input  logic [lps_pkg::VAL_W-1:0] mag_i,
  input  logic [3:0]                digit_i,
  output logic [lps_pkg::VAL_W-1:0] mag_o
);

  logic [35:0] sum;

  // x*10 = x*8 + x*2
  assign sum = {1'b0, mag_i, 3'b000} + {3'b000, mag_i, 1'b0} + {32'd0, digit_i};

  assign mag_o = (sum > {4'd0, lps_pkg::MAG_LIMIT}) ? lps_pkg::MAG_CLAMP : sum[31:0];

endmodule
